### hdl/kpd_pkg.sv
// kmer_profile_distance shared package: widths, controller states, command/status types
// no dependencies
package kpd_pkg;

  localparam int unsigned MaxK      = 8;
  localparam int unsigned MaxLen    = 65535;
  localparam int unsigned AddrW     = 2 * MaxK;
  localparam int unsigned CntW      = 16;
  localparam int unsigned LenW      = 16;
  localparam int unsigned KW        = 4;
  localparam int unsigned DistW     = 17;
  localparam int unsigned QuotBits  = 17;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } kpd_state_e;

  typedef struct packed {
    logic clr_start;   // begin clearing sweep (also resets counters/flags)
    logic take_base;   // register an accepted base
    logic upd;         // read-modify-write of the table
    logic scan_start;
    logic div_start;
  } kpd_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic pair_done;   // both sequences finished after this base
    logic scan_done;
    logic div_done;
  } kpd_sts_t;

  function automatic logic [1:0] base_code(input logic [7:0] b);
    case (b)
      8'h43, 8'h63: base_code = 2'd1;
      8'h47, 8'h67: base_code = 2'd2;
      8'h54, 8'h74: base_code = 2'd3;
      default:      base_code = 2'd0;
    endcase
  endfunction

endpackage

### hdl/kpd_ctrl.sv
// kmer_profile_distance controller state machine
// depends on kpd_pkg
module kpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  kpd_pkg::kpd_sts_t sts_i,
  output kpd_pkg::kpd_cmd_t cmd_o,
  output logic              idle_o
);
  import kpd_pkg::*;

  kpd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    idle_o    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        idle_o   = 1'b1;
        if (in_valid) begin
          cmd_o.take_base = 1'b1;
          state_d         = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        if (sts_i.pair_done) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd_o.clr_start = 1'b1;
          state_d         = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  a_stall_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall) else $error("input taken outside idle");
  a_out_only_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (state_q == ST_OUT)) else $error("result outside out state");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

### hdl/kpd_datapath.sv
// kmer_profile_distance datapath: count tables, windows, lengths, scan and divider
// depends on kpd_pkg
module kpd_datapath #(
  parameter int unsigned MAX_LEN = kpd_pkg::MaxLen
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kpd_pkg::kpd_cmd_t          cmd_i,
  output kpd_pkg::kpd_sts_t          sts_o,
  input  logic [kpd_pkg::KW-1:0]     kmer_len_i,
  input  logic                       seq_id_i,
  input  logic [7:0]                 base_i,
  input  logic                       last_i,
  output logic [kpd_pkg::DistW-1:0]  distance_q16_o,
  output logic [kpd_pkg::CntW-1:0]   shared_count_o,
  output logic                       too_short_o,
  output logic                       length_overflow_o
);
  import kpd_pkg::*;

  localparam int unsigned Depth = 1 << AddrW;

  logic [CntW-1:0] tab0 [Depth];
  logic [CntW-1:0] tab1 [Depth];

  logic [AddrW:0]    clr_cnt_q;
  logic              clearing_q;
  logic [LenW-1:0]   len_q [2];
  logic [15:0]       win_q [2];
  logic [1:0]        done_q;
  logic              ovf_q;
  logic              sid_q, last_q;
  logic [1:0]        code_q;
  logic [KW-1:0]     k_eff;
  logic [AddrW-1:0]  mask;

  // effective k
  always_comb begin
    k_eff = kmer_len_i;
    if (kmer_len_i == '0) begin
      k_eff = KW'(1);
    end else if (kmer_len_i > KW'(MaxK)) begin
      k_eff = KW'(MaxK);
    end
    mask = AddrW'((17'(1) << (5'(k_eff) << 1)) - 17'(1));
  end

  // base update logic
  logic              act;
  logic              do_add;
  logic [LenW-1:0]   len_new;
  logic [15:0]       win_new;
  logic [AddrW-1:0]  idx;
  logic [CntW-1:0]   rd0_q, rd1_q;
  logic [AddrW-1:0]  rd_addr;

  always_comb begin
    act     = !done_q[sid_q];
    len_new = len_q[sid_q] + LenW'(1);
    win_new = {win_q[sid_q][13:0], code_q};
    do_add  = act && (32'(len_q[sid_q]) < MAX_LEN) && (32'(len_new) >= 32'(k_eff));
    idx     = win_new & mask;
  end

  // scan
  logic              scanning_q;
  logic [AddrW:0]    scan_cnt_q;
  logic              scan_v_q;
  logic [16:0]       sum_q;
  logic [CntW-1:0]   shared;
  logic [CntW-1:0]   mn;

  always_comb begin
    if (scanning_q) begin
      rd_addr = scan_cnt_q[AddrW-1:0];
    end else if (cmd_i.take_base) begin
      rd_addr = {win_q[seq_id_i][13:0], base_code(base_i)} & mask;
    end else begin
      rd_addr = idx;
    end
    mn = (rd0_q < rd1_q) ? rd0_q : rd1_q;
  end

  always_ff @(posedge clk_i) begin
    rd0_q <= tab0[rd_addr];
    rd1_q <= tab1[rd_addr];
    if (clearing_q) begin
      tab0[clr_cnt_q[AddrW-1:0]] <= '0;
      tab1[clr_cnt_q[AddrW-1:0]] <= '0;
    end else if (cmd_i.upd && do_add) begin
      if (sid_q) begin
        if (rd1_q != '1) tab1[idx] <= rd1_q + CntW'(1);
      end else begin
        if (rd0_q != '1) tab0[idx] <= rd0_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      len_q[0]   <= '0;
      len_q[1]   <= '0;
      win_q[0]   <= '0;
      win_q[1]   <= '0;
      done_q     <= '0;
      ovf_q      <= 1'b0;
      scanning_q <= 1'b0;
      scan_cnt_q <= '0;
      scan_v_q   <= 1'b0;
      sum_q      <= '0;
    end else begin
      if (cmd_i.clr_start) begin
        clearing_q <= 1'b1;
        clr_cnt_q  <= '0;
        len_q[0]   <= '0;
        len_q[1]   <= '0;
        win_q[0]   <= '0;
        win_q[1]   <= '0;
        done_q     <= '0;
        ovf_q      <= 1'b0;
      end else if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + (AddrW+1)'(1);
        if (clr_cnt_q == (AddrW+1)'(Depth - 1)) clearing_q <= 1'b0;
      end
      if (cmd_i.upd && act) begin
        if (32'(len_q[sid_q]) >= MAX_LEN) begin
          ovf_q <= 1'b1;
        end else begin
          len_q[sid_q] <= len_new;
          win_q[sid_q] <= win_new;
        end
        if (last_q) done_q[sid_q] <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        scanning_q <= 1'b1;
        scan_cnt_q <= '0;
        sum_q      <= '0;
        scan_v_q   <= 1'b0;
      end else begin
        scan_v_q <= scanning_q;
        if (scanning_q) begin
          scan_cnt_q <= scan_cnt_q + (AddrW+1)'(1);
          if (scan_cnt_q == (AddrW+1)'(Depth - 1)) scanning_q <= 1'b0;
        end
        if (scan_v_q) begin
          sum_q <= (sum_q + 17'(mn) > 17'hFFFF) ? 17'hFFFF : sum_q + 17'(mn);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_base) begin
      sid_q  <= seq_id_i;
      last_q <= last_i;
      code_q <= base_code(base_i);
    end
  end

  assign shared = sum_q[CntW-1:0];
  assign sts_o.clr_done  = clearing_q && (clr_cnt_q == (AddrW+1)'(Depth - 1));
  assign sts_o.pair_done = ((done_q | ((act && last_q) ? (2'b01 << sid_q) : 2'b00)) == 2'b11);
  assign sts_o.scan_done = !scanning_q && !scan_v_q;

  // restoring divider: (shared << 16) / denom
  logic [LenW-1:0]     minlen;
  logic [LenW:0]       denom_q;
  logic [QuotBits-1:0] quot_q;
  logic [LenW:0]       rem_q;
  logic [32:0]         num_q;
  logic [5:0]          dcnt_q;
  logic                dbusy_q;
  logic                ts_q, sat_q;
  logic [LenW+1:0]     trial;

  assign minlen = (len_q[0] < len_q[1]) ? len_q[0] : len_q[1];
  assign trial  = {rem_q, num_q[32]} - {1'b0, denom_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= 6'd33;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 6'd1;
      if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      ts_q    <= 32'(minlen) < 32'(k_eff);
      denom_q <= (LenW+1)'(minlen) - (LenW+1)'(k_eff) + (LenW+1)'(1);
      sat_q   <= (LenW+1)'(shared) >= (LenW+1)'(minlen) - (LenW+1)'(k_eff) + (LenW+1)'(1);
      num_q   <= {1'b0, shared, 16'd0};
      rem_q   <= '0;
      quot_q  <= '0;
    end else if (dbusy_q) begin
      num_q <= {num_q[31:0], 1'b0};
      if (!trial[LenW+1]) begin
        rem_q  <= trial[LenW:0];
        quot_q <= {quot_q[QuotBits-2:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[LenW-1:0], num_q[32]};
        quot_q <= {quot_q[QuotBits-2:0], 1'b0};
      end
    end
  end

  assign sts_o.div_done = dbusy_q && (dcnt_q == 6'd1);

  always_comb begin
    if (ts_q) begin
      distance_q16_o = DistW'(65536);
    end else if (sat_q) begin
      distance_q16_o = '0;
    end else begin
      distance_q16_o = DistW'(65536) - quot_q;
    end
  end
  assign shared_count_o    = shared;
  assign too_short_o       = ts_q;
  assign length_overflow_o = ovf_q;

  a_no_clear_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clearing_q && scanning_q)) else $error("clear and scan overlap");
  a_no_upd_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> !clearing_q) else $error("update during clear");
  a_sum_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= 17'hFFFF) else $error("sum above cap");

endmodule

### hdl/kmer_profile_distance.sv
// k-mer profile distance: each base is read from the count tables, then its count is written back;
// the pair-completing base adds a full table scan, a divide and a result state that holds until taken;
// after reset and after each result, a table clear accepts no base.
// depends on kpd_pkg, kpd_ctrl, kpd_datapath
module kmer_profile_distance #(
  parameter int unsigned MAX_LEN = kpd_pkg::MaxLen
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       seq_id_i,
  input  logic [7:0]                 base_i,
  input  logic                       last_i,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kpd_pkg::DistW-1:0]  distance_q16_o,
  output logic [kpd_pkg::CntW-1:0]   shared_count_o,
  output logic                       too_short_o,
  output logic                       length_overflow_o,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kpd_pkg::KW-1:0]     cfg_data
);
  import kpd_pkg::*;

  kpd_cmd_t       cmd;
  kpd_sts_t       sts;
  logic           idle;
  logic [KW-1:0]  kmer_len_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= KW'(4);
    end else if (cfg_valid) begin
      kmer_len_q <= cfg_data;
    end
  end

  kpd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd), .idle_o(idle)
  );

  kpd_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .kmer_len_i(kmer_len_q), .seq_id_i, .base_i, .last_i,
    .distance_q16_o, .shared_count_o, .too_short_o, .length_overflow_o
  );

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |-> idle) else $error("base taken while busy");
  a_take_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |=> cmd.upd) else $error("missing update");
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(sts.div_done)) else $error("result before divide");

endmodule
